>>> rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package lkvc_pkg;

    // default number of entries
    localparam int MAX_ENTRIES = 16;

    // fixed field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;
    localparam int OCC_W = 5;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request types
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_SET = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // transaction accepted: latch request and lane compares
        logic fire;     // apply the update and load the result register
    } lkvc_cmd_t;

endpackage

`default_nettype wire

>>> rtl/lkvc_if.sv
// Request and response channel interfaces of the LRU key-value cache.
// Depends on lkvc_pkg for the field widths.
`default_nettype none

interface lkvc_req_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic signed [lkvc_pkg::KEY_W-1:0] req_key;
    logic signed [lkvc_pkg::VAL_W-1:0] req_value;

    modport source (output valid, output req_type, output req_key, output req_value,
                    input ready);
    modport sink   (input valid, input req_type, input req_key, input req_value,
                    output ready);
endinterface

interface lkvc_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic signed [lkvc_pkg::VAL_W-1:0] read_value;
    logic        [lkvc_pkg::OCC_W-1:0] occupancy;

    modport source (output valid, output hit, output read_value, output occupancy,
                    input ready);
    modport sink   (input valid, input hit, input read_value, input occupancy,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/lkvc_ctrl.sv
// Controller of the LRU key-value cache: request handshake, sequencing, result valid.
// Depends on lkvc_pkg for the command struct.
`default_nettype none

module lkvc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      lkvc_pkg::lkvc_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   fire;

    // handshake and commands
    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign fire        = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign cmd.capture = accept;
    assign cmd.fire    = fire;
    assign out_valid   = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid: set on update, cleared when taken
    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/lkvc_datapath.sv
// Datapath of the LRU key-value cache: key lanes, recency ranks, value memory,
// capacity register and result register. Depends on lkvc_pkg.
`default_nettype none

module lkvc_datapath #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire lkvc_pkg::lkvc_cmd_t                cmd,
    input  wire logic                               cfg_we,
    input  wire logic        [lkvc_pkg::CAP_W-1:0]  cfg_wdata,
    input  wire logic                               in_type,
    input  wire logic signed [lkvc_pkg::KEY_W-1:0]  in_key,
    input  wire logic signed [lkvc_pkg::VAL_W-1:0]  in_value,
    output      logic                               out_hit,
    output      logic signed [lkvc_pkg::VAL_W-1:0]  out_read_value,
    output      logic        [lkvc_pkg::OCC_W-1:0]  out_occupancy
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

    // configuration and per-lane state
    logic [lkvc_pkg::CAP_W-1:0] capacity_reg;
    logic [lkvc_pkg::KEY_W-1:0] lane_key_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]     valid_reg, valid_next;
    logic [IDX_W-1:0]           rank_reg [MAX_ENTRIES];
    logic [IDX_W-1:0]           rank_next [MAX_ENTRIES];
    logic [CNT_W-1:0]           count_reg, count_next;

    // value store
    logic [lkvc_pkg::VAL_W-1:0] value_mem [MAX_ENTRIES];
    logic [lkvc_pkg::VAL_W-1:0] rd_data_reg;

    // captured request and lane compares
    logic                       req_type_reg;
    logic [lkvc_pkg::KEY_W-1:0] req_key_reg;
    logic [lkvc_pkg::VAL_W-1:0] req_value_reg;
    logic [MAX_ENTRIES-1:0]     match_reg, lru_reg, lru2_reg;
    logic [MAX_ENTRIES-1:0]     match_c, lru_c, lru2_c;

    // result register
    logic                       hit_out_reg;
    logic [lkvc_pkg::OCC_W-1:0] occ_out_reg;

    // update signals
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       hit_rank;
    logic                   hit_any;
    logic                   lru_is_hit;
    logic [CMP_W-1:0]       cap_eff;
    logic [CMP_W-1:0]       count_w;
    logic                   is_set;
    logic                   insert;
    logic                   do_insert;
    logic [MAX_ENTRIES-1:0] evict_v;
    logic [MAX_ENTRIES-1:0] valid_after;
    logic [IDX_W-1:0]       slot;
    logic                   slot_found;
    logic [CNT_W-1:0]       count_m1;
    logic [CNT_W-1:0]       count_m2;

    // lane compares against the incoming key and the two oldest ranks
    assign count_m1 = count_reg - CNT_W'(1);
    assign count_m2 = count_reg - CNT_W'(2);

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            match_c[i] = valid_reg[i] && (lane_key_reg[i] == in_key);
            lru_c[i]   = valid_reg[i] && (CNT_W'(rank_reg[i]) == count_m1);
            lru2_c[i]  = valid_reg[i] && (CNT_W'(rank_reg[i]) == count_m2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg  <= in_type;
            req_key_reg   <= in_key;
            req_value_reg <= in_value;
            match_reg     <= match_c;
            lru_reg       <= lru_c;
            lru2_reg      <= lru2_c;
        end
    end

    // hit lane index and rank, by and-or over the lanes
    always_comb
    begin
        hit_idx  = '0;
        hit_rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (match_reg[i])
            begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | rank_reg[i];
            end
        end
    end

    assign hit_any    = |match_reg;
    assign lru_is_hit = |(match_reg & lru_reg);
    assign is_set     = (req_type_reg == lkvc_pkg::REQ_SET);
    assign count_w    = CMP_W'(count_reg);
    assign cap_eff    = (CMP_W'(capacity_reg) > CMP_W'(MAX_ENTRIES)) ?
                        CMP_W'(MAX_ENTRIES) : CMP_W'(capacity_reg);
    assign insert     = is_set && !hit_any && ((count_reg != '0) || (cap_eff != '0));

    // eviction choice; an overwrite of the oldest entry shifts the oldest to the next one
    always_comb
    begin
        evict_v = '0;
        if (is_set && hit_any)
        begin
            if (count_w > cap_eff)
            begin
                if (!lru_is_hit)
                begin
                    evict_v = lru_reg;
                end
                else if (count_reg == CNT_W'(1))
                begin
                    evict_v = match_reg;
                end
                else
                begin
                    evict_v = lru2_reg;
                end
            end
        end
        else if (insert && (count_w >= cap_eff))
        begin
            evict_v = lru_reg;
        end
    end

    assign valid_after = valid_reg & ~evict_v;

    // first free lane after the eviction
    always_comb
    begin
        slot       = '0;
        slot_found = 1'b0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_after[i])
            begin
                slot       = IDX_W'(i);
                slot_found = 1'b1;
            end
        end
    end

    assign do_insert = insert && slot_found;

    // next valid bits and ranks
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            valid_next[i] = valid_after[i] || (do_insert && (slot == IDX_W'(i)));
            rank_next[i]  = rank_reg[i];
            if (evict_v[i])
            begin
                rank_next[i] = '0;
            end
            else if (hit_any)
            begin
                if (match_reg[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
            else if (do_insert)
            begin
                if (slot == IDX_W'(i))
                begin
                    rank_next[i] = '0;
                end
                else if (valid_after[i])
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
        end
    end

    assign count_next = count_reg - CNT_W'(|evict_v) + CNT_W'(do_insert);

    // control state of the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkvc_pkg::CAP_RESET;
            valid_reg    <= '0;
            count_reg    <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (cmd.fire)
            begin
                valid_reg <= valid_next;
                count_reg <= count_next;
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    rank_reg[i] <= rank_next[i];
                end
            end
        end
    end

    // key lanes
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (cmd.fire && do_insert && (slot == IDX_W'(i)))
            begin
                lane_key_reg[i] <= req_key_reg;
            end
        end
    end

    // value memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.fire)
        begin
            if (is_set && hit_any)
            begin
                value_mem[hit_idx] <= req_value_reg;
            end
            else if (do_insert)
            begin
                value_mem[slot] <= req_value_reg;
            end
            rd_data_reg <= value_mem[hit_idx];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.fire)
        begin
            hit_out_reg <= !is_set && hit_any;
            occ_out_reg <= lkvc_pkg::OCC_W'(count_next);
        end
    end

    assign out_hit        = hit_out_reg;
    assign out_read_value = hit_out_reg ? rd_data_reg : '0;
    assign out_occupancy  = occ_out_reg;

endmodule

`default_nettype wire

>>> rtl/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// In a transaction the accepting edge latches the request and the parallel key
// compare of every lane; the update edge, taken once the response register is free
// or being read, applies the recency update and the value memory access and loads
// the response register. The response register lets a new request be accepted
// while the previous response waits. The entry count is set by MAX_ENTRIES;
// capacity resets to 16. The user must write it only while the block is idle;
// the block itself does not enforce this. Keys and values of entries never written
// hold no defined content; there is no clearing pass after reset.
// Depends on lkvc_pkg, lkvc_if, lkvc_ctrl and lkvc_datapath.
`default_nettype none

module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    lkvc_req_if.sink                        req,
    lkvc_rsp_if.source                      rsp,
    input  wire logic                       cfg_we,
    input  wire logic [lkvc_pkg::CAP_W-1:0] cfg_wdata
);

    lkvc_pkg::lkvc_cmd_t cmd;

    // sequencing and handshakes
    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // lanes, memory and result register
    lkvc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_type        (req.req_type),
        .in_key         (req.req_key),
        .in_value       (req.req_value),
        .out_hit        (rsp.hit),
        .out_read_value (rsp.read_value),
        .out_occupancy  (rsp.occupancy)
    );

endmodule

`default_nettype wire

>>> tb/sv/lru_key_value_cache_test.sv
// Self-checking testbench for the LRU key-value cache: directed and random get/set traffic.
// It checks every response against a shadow copy of the cache kept in the testbench.
// Depends on lkvc_pkg, lkvc_if and the lru_key_value_cache top level.

module lru_key_value_cache_test;

    import lkvc_pkg::*;

    localparam int DEPTH        = MAX_ENTRIES;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;

    // one expected response
    typedef struct packed {
        logic                    hit;
        logic        [VAL_W-1:0] read_value;
        logic        [OCC_W-1:0] occupancy;
    } cache_response_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    lkvc_req_if req ();
    lkvc_rsp_if rsp ();

    lru_key_value_cache i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // shadow copy of the cache contents
    logic [KEY_W-1:0] cached_key   [DEPTH];
    logic [VAL_W-1:0] cached_value [DEPTH];
    bit               slot_used    [DEPTH];
    int               age_rank     [DEPTH];
    int               stored_count;
    logic [CAP_W-1:0] capacity_setting;

    cache_response_t pending_responses [$];

    int mismatches;
    int cycle_count;
    int burst_left;
    bit steady_flow;
    int hold_request;
    int hold_left;
    int ready_run;
    bit ready_state;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // move an entry to the front of the recency order
    function automatic void promote_entry(input int e);
        int r;
        r = age_rank[e];
        for (int i = 0; i < DEPTH; i++)
            if (slot_used[i] && age_rank[i] < r)
                age_rank[i]++;
        age_rank[e] = 0;
    endfunction

    // drop the least recent entry, if there is one
    function automatic void evict_oldest_entry();
        for (int i = 0; i < DEPTH; i++)
        begin
            if (slot_used[i] && age_rank[i] + 1 == stored_count)
            begin
                slot_used[i] = 1'b0;
                age_rank[i]  = 0;
                stored_count--;
                return;
            end
        end
    endfunction

    // apply one request to the shadow cache and work out its response
    function automatic cache_response_t predict_cache_response(input logic kind,
                                                                input logic [KEY_W-1:0] key,
                                                                input logic [VAL_W-1:0] value);
        cache_response_t r;
        int found;
        int slot;
        int limit;
        r     = '0;
        found = -1;
        slot  = -1;
        limit = (capacity_setting > DEPTH) ? DEPTH : int'(capacity_setting);
        for (int i = 0; i < DEPTH; i++)
            if (slot_used[i] && cached_key[i] == key)
                found = i;
        if (kind == REQ_GET)
        begin
            if (found >= 0)
            begin
                r.hit        = 1'b1;
                r.read_value = cached_value[found];
                promote_entry(found);
            end
        end
        else if (found >= 0)
        begin
            // overwrite, then trim by at most one entry
            cached_value[found] = value;
            promote_entry(found);
            if (stored_count > limit)
                evict_oldest_entry();
        end
        else if (stored_count > 0 || limit > 0)
        begin
            // new key: make room first, then take the first free slot
            if (stored_count + 1 > limit)
                evict_oldest_entry();
            for (int i = 0; i < DEPTH; i++)
                if (!slot_used[i] && slot < 0)
                    slot = i;
            if (slot >= 0)
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (slot_used[i])
                        age_rank[i]++;
                cached_key[slot]   = key;
                cached_value[slot] = value;
                slot_used[slot]    = 1'b1;
                age_rank[slot]     = 0;
                stored_count++;
            end
        end
        r.occupancy = stored_count[OCC_W-1:0];
        return r;
    endfunction

    // offer one request transaction; bursts with random gaps unless in steady flow
    task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady_flow ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        req.valid     <= 1'b1;
        req.req_type  <= kind;
        req.req_key   <= key;
        req.req_value <= value;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_responses.push_back(predict_cache_response(kind, key, value));
        burst_left--;
    endtask

    // stop offering and wait until every expected response has arrived
    task automatic wait_for_responses();
        req.valid <= 1'b0;
        burst_left = 0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // capacity is only written with the block idle
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_for_responses();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
        capacity_setting = cap;
    endtask

    // extreme keys and values, hits, misses and an overwrite
    task automatic test_lookup_and_store();
        write_capacity(CAP_RESET);
        send_request(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(REQ_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(REQ_SET, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(REQ_GET, 32'h7FFF_FFFF, 32'h5555_5555);
        send_request(REQ_SET, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
        send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    // fill every slot, then store a new key so the least recent one goes
    task automatic test_full_cache_replacement();
        for (int k = 0; k < 12; k++)
            send_request(REQ_SET, 32'h0000_0100 + k, $urandom());
        send_request(REQ_SET, 32'h1111_0000, 32'h2222_0000);
        send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    endtask

    // capacity dropped below occupancy: each set trims one entry only
    task automatic test_capacity_lowered();
        write_capacity(5'd3);
        send_request(REQ_SET, 32'h00C0_FFEE, 32'h1234_5678);
        send_request(REQ_SET, 32'h00C0_FFEE, 32'h8765_4321);
        send_request(REQ_GET, 32'h00C0_FFEE, 32'h0000_0000);
        send_request(REQ_SET, 32'h00C0_FFEF, 32'h0F0F_0F0F);
    endtask

    // zero capacity: overwrite of the sole entry drops it, then nothing is stored
    task automatic test_zero_capacity();
        write_capacity(5'd1);
        send_request(REQ_SET, 32'h0BAD_F00D, 32'hDEAD_BEEF);
        write_capacity(5'd0);
        send_request(REQ_GET, 32'h0BAD_F00D, 32'h0000_0000);
        send_request(REQ_SET, 32'h0BAD_F00D, 32'h1357_9BDF);
        send_request(REQ_SET, 32'h0BAD_F00E, 32'h2468_ACE0);
        send_request(REQ_GET, 32'h0BAD_F00E, 32'h0000_0000);
        send_request(REQ_GET, 32'h0BAD_F00D, 32'h0000_0000);
    endtask

    // random gets and sets, mostly over a key pool a little larger than the capacity
    task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int count);
        logic [KEY_W-1:0] key_pool [32];
        logic [KEY_W-1:0] key;
        logic             kind;
        int               limit;
        int               pool_size;
        write_capacity(cap);
        limit     = (cap > DEPTH) ? DEPTH : int'(cap);
        pool_size = limit + limit / 2 + 2;
        for (int k = 0; k < 32; k++)
            key_pool[k] = $urandom();
        for (int n = 0; n < count; n++)
        begin
            if (n % 64 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 1) ? REQ_SET : REQ_GET;
            key  = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, pool_size - 1)]
                                              : $urandom();
            send_request(kind, key, $urandom());
        end
        steady_flow = 1'b0;
    endtask

    // long response stall fills the block; then a full pause before more traffic
    task automatic test_backpressure();
        write_capacity(5'd6);
        steady_flow  = 1'b1;
        hold_request = 80;
        for (int n = 0; n < 40; n++)
            send_request($urandom_range(0, 1) ? REQ_SET : REQ_GET, $urandom_range(0, 9),
                         $urandom());
        wait_for_responses();
        for (int n = 0; n < 20; n++)
            send_request($urandom_range(0, 1) ? REQ_SET : REQ_GET, $urandom_range(0, 9),
                         $urandom());
        steady_flow = 1'b0;
    endtask

    // response side: long hold when asked, always ready in steady flow, else random runs
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            rsp.ready <= 1'b0;
            hold_left--;
        end
        else if (steady_flow)
            rsp.ready <= 1'b1;
        else
        begin
            if (ready_run == 0)
            begin
                ready_state = ($urandom_range(0, 99) < 70);
                ready_run   = ready_state ? $urandom_range(1, 12) : $urandom_range(1, 5);
            end
            ready_run--;
            rsp.ready <= ready_state;
        end
    end

    // report one field that differs
    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    // compare each response transaction with the oldest expectation
    always @(posedge clk)
    begin
        cache_response_t due;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_responses.size() == 0)
            begin
                mismatches++;
                $display("%0t: response with nothing expected, actual hit %b value %h occ %0d",
                         $time, rsp.hit, rsp.read_value, rsp.occupancy);
            end
            else
            begin
                due = pending_responses.pop_front();
                if (rsp.hit !== due.hit)
                    note_mismatch("hit", 32'(due.hit), 32'(rsp.hit));
                if (rsp.read_value !== due.read_value)
                    note_mismatch("read_value", due.read_value, rsp.read_value);
                if (rsp.occupancy !== due.occupancy)
                    note_mismatch("occupancy", 32'(due.occupancy), 32'(rsp.occupancy));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("lru_key_value_cache regression: fail");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        logic [CAP_W-1:0] mid_capacity;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        req.valid     <= 1'b0;
        req.req_type  <= REQ_GET;
        req.req_key   <= '0;
        req.req_value <= '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_used[i] = 1'b0;
            age_rank[i]  = 0;
        end
        stored_count     = 0;
        capacity_setting = CAP_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_lookup_and_store();
        test_full_cache_replacement();
        test_capacity_lowered();
        test_random_traffic(5'd16, 300);
        test_random_traffic(5'd1, 150);
        test_zero_capacity();
        test_random_traffic(5'd0, 60);
        test_random_traffic(5'd31, 250);
        test_backpressure();
        test_random_traffic(5'd8, 200);
        mid_capacity = CAP_W'($urandom_range(2, 15));
        test_random_traffic(mid_capacity, 200);
        test_random_traffic(5'd17, 150);
        test_random_traffic(5'd2, 150);
        wait_for_responses();

        if (mismatches == 0)
            $display("lru_key_value_cache regression: pass");
        else
            $display("lru_key_value_cache regression: fail");
        $finish;
    end

endmodule
